[rtl/slp1dev_pkg.sv]
package slp1dev_pkg;

    // Kinds of the main group of bytes that one input item produces.
    localparam logic [1:0] KIND_NONE = 2'd0;  // no main bytes
    localparam logic [1:0] KIND_CODE = 2'd1;  // three bytes: lead, b1, b2
    localparam logic [1:0] KIND_RAW  = 2'd2;  // one byte passed through in b2

    // UTF-8 bytes of the Devanagari block.
    localparam logic [7:0] UTF8_LEAD    = 8'hE0;
    localparam logic [7:0] PAGE_A4      = 8'hA4;
    localparam logic [7:0] PAGE_A5      = 8'hA5;
    localparam logic [7:0] VIRAMA_LOW   = 8'h8D;
    localparam logic [7:0] ANUSVARA_LOW = 8'h82;
    localparam logic [7:0] VISARGA_LOW  = 8'h83;

    // SLP1 symbols handled on their own.
    localparam logic [7:0] SYM_SHORT_A  = 8'h61;  // 'a'
    localparam logic [7:0] SYM_ANUSVARA = 8'h4D;  // 'M'
    localparam logic [7:0] SYM_VISARGA  = 8'h48;  // 'H'

    // Decoded lookup: hit flag and the two bytes after the lead byte.
    typedef struct packed {
        logic       hit;
        logic [7:0] b1;
        logic [7:0] b2;
    } sym_code_t;

    // Work for one item, handed from the front to the back.
    typedef struct packed {
        logic       pre_virama;
        logic [1:0] main_kind;
        logic [7:0] main_b1;
        logic [7:0] main_b2;
        logic       post_virama;
        logic       text_end;
    } cmd_t;

    // Standalone vowel letters.
    function automatic sym_code_t vowel_std_lookup(input logic [7:0] sym);
        sym_code_t r;
        r = '{hit: 1'b1, b1: PAGE_A4, b2: 8'h00};
        case (sym)
            8'h61: r.b2 = 8'h85;  // a
            8'h41: r.b2 = 8'h86;  // A
            8'h69: r.b2 = 8'h87;  // i
            8'h49: r.b2 = 8'h88;  // I
            8'h75: r.b2 = 8'h89;  // u
            8'h55: r.b2 = 8'h8A;  // U
            8'h66: r.b2 = 8'h8B;  // f
            8'h46: begin          // F
                r.b1 = PAGE_A5;
                r.b2 = 8'hA0;
            end
            8'h78: r.b2 = 8'h8C;  // x
            8'h65: r.b2 = 8'h8F;  // e
            8'h45: r.b2 = 8'h90;  // E
            8'h6F: r.b2 = 8'h93;  // o
            8'h4F: r.b2 = 8'h94;  // O
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // Dependent vowel marks; the short 'a' has none.
    function automatic sym_code_t vowel_mark_lookup(input logic [7:0] sym);
        sym_code_t r;
        r = '{hit: 1'b1, b1: PAGE_A5, b2: 8'h00};
        case (sym)
            8'h41: begin          // A
                r.b1 = PAGE_A4;
                r.b2 = 8'hBE;
            end
            8'h69: begin          // i
                r.b1 = PAGE_A4;
                r.b2 = 8'hBF;
            end
            8'h49: r.b2 = 8'h80;  // I
            8'h75: r.b2 = 8'h81;  // u
            8'h55: r.b2 = 8'h82;  // U
            8'h66: r.b2 = 8'h83;  // f
            8'h46: r.b2 = 8'h84;  // F
            8'h78: r.b2 = 8'h8C;  // x, shares the mark of O
            8'h65: r.b2 = 8'h87;  // e
            8'h45: r.b2 = 8'h88;  // E
            8'h6F: r.b2 = 8'h8B;  // o
            8'h4F: r.b2 = 8'h8C;  // O
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // Consonant letters, all on page A4.
    function automatic sym_code_t cons_lookup(input logic [7:0] sym);
        sym_code_t r;
        r = '{hit: 1'b1, b1: PAGE_A4, b2: 8'h00};
        case (sym)
            8'h6B: r.b2 = 8'h95;  // k
            8'h4B: r.b2 = 8'h96;  // K
            8'h67: r.b2 = 8'h97;  // g
            8'h47: r.b2 = 8'h98;  // G
            8'h4E: r.b2 = 8'h99;  // N
            8'h63: r.b2 = 8'h9A;  // c
            8'h43: r.b2 = 8'h9B;  // C
            8'h6A: r.b2 = 8'h9C;  // j
            8'h4A: r.b2 = 8'h9D;  // J
            8'h59: r.b2 = 8'h9E;  // Y
            8'h77: r.b2 = 8'h9F;  // w
            8'h57: r.b2 = 8'hA0;  // W
            8'h71: r.b2 = 8'hA1;  // q
            8'h51: r.b2 = 8'hA2;  // Q
            8'h52: r.b2 = 8'hA3;  // R
            8'h74: r.b2 = 8'hA4;  // t
            8'h54: r.b2 = 8'hA5;  // T
            8'h64: r.b2 = 8'hA6;  // d
            8'h44: r.b2 = 8'hA7;  // D
            8'h6E: r.b2 = 8'hA8;  // n
            8'h70: r.b2 = 8'hAA;  // p
            8'h50: r.b2 = 8'hAB;  // P
            8'h62: r.b2 = 8'hAC;  // b
            8'h42: r.b2 = 8'hAD;  // B
            8'h6D: r.b2 = 8'hAE;  // m
            8'h79: r.b2 = 8'hAF;  // y
            8'h72: r.b2 = 8'hB0;  // r
            8'h6C: r.b2 = 8'hB2;  // l
            8'h76: r.b2 = 8'hB5;  // v
            8'h53: r.b2 = 8'hB6;  // S
            8'h7A: r.b2 = 8'hB7;  // z
            8'h73: r.b2 = 8'hB8;  // s
            8'h68: r.b2 = 8'hB9;  // h
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/slp1dev_front.sv]
module slp1dev_front
    import slp1dev_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] symbol,
    input  logic       has_symbol,
    input  logic       end_of_text,
    input  logic       queue_full,
    output logic       in_stall,
    output logic       push,
    output cmd_t       push_cmd
);

    logic      after_consonant_reg;
    logic      after_consonant_next;
    logic      ac_mid;
    logic      accept;
    sym_code_t vstd;
    sym_code_t vmark;
    sym_code_t cons;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // Classify the symbol against the consonant flag and build the command.
    always_comb
    begin
        vstd     = vowel_std_lookup(symbol);
        vmark    = vowel_mark_lookup(symbol);
        cons     = cons_lookup(symbol);
        push_cmd = '0;
        ac_mid   = after_consonant_reg;
        if (has_symbol)
        begin
            if (vstd.hit)
            begin
                if (!after_consonant_reg)
                begin
                    push_cmd.main_kind = KIND_CODE;
                    push_cmd.main_b1   = vstd.b1;
                    push_cmd.main_b2   = vstd.b2;
                end
                else if (symbol != SYM_SHORT_A)
                begin
                    push_cmd.main_kind = KIND_CODE;
                    push_cmd.main_b1   = vmark.b1;
                    push_cmd.main_b2   = vmark.b2;
                end
                ac_mid = 1'b0;
            end
            else if (cons.hit)
            begin
                push_cmd.pre_virama = after_consonant_reg;
                push_cmd.main_kind  = KIND_CODE;
                push_cmd.main_b1    = cons.b1;
                push_cmd.main_b2    = cons.b2;
                ac_mid              = 1'b1;
            end
            else if (symbol == SYM_ANUSVARA || symbol == SYM_VISARGA)
            begin
                push_cmd.pre_virama = after_consonant_reg;
                push_cmd.main_kind  = KIND_CODE;
                push_cmd.main_b1    = PAGE_A4;
                push_cmd.main_b2    = (symbol == SYM_ANUSVARA) ? ANUSVARA_LOW : VISARGA_LOW;
                ac_mid              = 1'b0;
            end
            else
            begin
                push_cmd.pre_virama = after_consonant_reg;
                push_cmd.main_kind  = KIND_RAW;
                push_cmd.main_b2    = symbol;
                ac_mid              = 1'b0;
            end
        end
        push_cmd.text_end    = end_of_text;
        push_cmd.post_virama = end_of_text && ac_mid;
        after_consonant_next = end_of_text ? 1'b0 : ac_mid;
    end

    // Items that produce no bytes are consumed without a queue entry.
    assign push = accept && (push_cmd.pre_virama || push_cmd.post_virama ||
                             (push_cmd.main_kind != KIND_NONE));

    // Consonant flag advances on every accepted transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            after_consonant_reg <= 1'b0;
        else if (accept)
            after_consonant_reg <= after_consonant_next;
    end

endmodule

[rtl/slp1dev_queue.sv]
module slp1dev_queue
    import slp1dev_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

[rtl/slp1dev_back.sv]
module slp1dev_back
    import slp1dev_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_ready,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_item,
    output logic       last_of_text
);

    localparam logic [1:0] SEG_PRE  = 2'd0;
    localparam logic [1:0] SEG_MAIN = 2'd1;
    localparam logic [1:0] SEG_POST = 2'd2;

    cmd_t       cmd_reg;
    logic       busy_reg;
    logic [1:0] seg_reg;
    logic [1:0] pos_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       last_of_item_reg;
    logic       last_of_text_reg;

    logic       advance;
    logic [7:0] cur_byte;
    logic       seg_last;
    logic       has_next_seg;
    logic [1:0] next_seg;
    logic       item_last;
    logic [1:0] first_seg;

    // Byte of the current segment and the segment that follows it.
    always_comb
    begin
        cur_byte     = UTF8_LEAD;
        seg_last     = (pos_reg == 2'd2);
        has_next_seg = 1'b0;
        next_seg     = SEG_POST;
        case (seg_reg)
            SEG_PRE:
            begin
                cur_byte = (pos_reg == 2'd0) ? UTF8_LEAD :
                           (pos_reg == 2'd1) ? PAGE_A5 : VIRAMA_LOW;
                if (cmd_reg.main_kind != KIND_NONE)
                begin
                    has_next_seg = 1'b1;
                    next_seg     = SEG_MAIN;
                end
                else
                    has_next_seg = cmd_reg.post_virama;
            end
            SEG_MAIN:
            begin
                if (cmd_reg.main_kind == KIND_RAW)
                begin
                    cur_byte = cmd_reg.main_b2;
                    seg_last = 1'b1;
                end
                else
                    cur_byte = (pos_reg == 2'd0) ? UTF8_LEAD :
                               (pos_reg == 2'd1) ? cmd_reg.main_b1 : cmd_reg.main_b2;
                has_next_seg = cmd_reg.post_virama;
            end
            SEG_POST:
                cur_byte = (pos_reg == 2'd0) ? UTF8_LEAD :
                           (pos_reg == 2'd1) ? PAGE_A5 : VIRAMA_LOW;
            default:
                cur_byte = UTF8_LEAD;
        endcase
        item_last = seg_last && !has_next_seg;
    end

    // Starting segment of a fresh command.
    always_comb
    begin
        if (head_cmd.pre_virama)
            first_seg = SEG_PRE;
        else if (head_cmd.main_kind != KIND_NONE)
            first_seg = SEG_MAIN;
        else
            first_seg = SEG_POST;
    end

    assign advance = busy_reg && (!out_valid_reg || !out_stall);
    assign pop     = cmd_ready && (!busy_reg || (advance && item_last));

    // Sequencer over the segments of the command in hand.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            seg_reg  <= SEG_PRE;
            pos_reg  <= 2'd0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            seg_reg  <= first_seg;
            pos_reg  <= 2'd0;
        end
        else if (advance)
        begin
            if (item_last)
                busy_reg <= 1'b0;
            else if (seg_last)
            begin
                seg_reg <= next_seg;
                pos_reg <= 2'd0;
            end
            else
                pos_reg <= pos_reg + 2'd1;
        end
    end

    // Command payload held while it is expanded.
    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= head_cmd;
    end

    // Output register: one byte per transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg     <= cur_byte;
            last_of_item_reg <= item_last;
            last_of_text_reg <= item_last && cmd_reg.text_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_item = last_of_item_reg;
    assign last_of_text = last_of_text_reg;

endmodule

[rtl/slp1_to_devanagari_encoder.sv]
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid / in_stall | symbol, has_symbol, end_of_text
// output  | out       | out_valid/out_stall | out_byte, last_of_item, last_of_text
//
// An item becomes zero to nine output bytes, one byte per cycle from the back
// sequencer while the output is not stalled.
// The front accepts an item per cycle while the command queue has room; an
// item that makes no bytes is taken without a queue entry.
// rst_n clears the consonant flag, the queue and the output register.
// A stalled output holds its byte; the queue then fills and in_stall rises.
module slp1_to_devanagari_encoder
    import slp1dev_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] symbol,
    input  logic       has_symbol,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_item,
    output logic       last_of_text
);

    logic push;
    logic pop;
    logic queue_full;
    logic queue_not_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    slp1dev_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .symbol      (symbol),
        .has_symbol  (has_symbol),
        .end_of_text (end_of_text),
        .queue_full  (queue_full),
        .in_stall    (in_stall),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    slp1dev_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_cmd  (head_cmd)
    );

    slp1dev_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_ready    (queue_not_empty),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .last_of_text (last_of_text)
    );

endmodule

[rtl/slp1dev_checker.sv]
module slp1dev_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] symbol,
    input logic       has_symbol,
    input logic       end_of_text,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last_of_item,
    input logic       last_of_text
);

    // A stalled output byte holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) &&
                                   $stable(last_of_item) && $stable(last_of_text))
        else $error("output byte changed while stalled");

    // The end of a text always closes an item.
    a_text_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_text |-> last_of_item)
        else $error("last_of_text without last_of_item");

    // Bytes of one item follow each other without a gap.
    a_item_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_item |=> out_valid)
        else $error("gap inside the bytes of one item");

    // Nothing is offered right after reset is released.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind slp1_to_devanagari_encoder slp1dev_checker u_slp1dev_checker (.*);
